@@ sv/pjs_pkg.sv @@
package pjs_pkg;

  // Width of the frame counters and job counts on the result ports
  localparam int CNT6_W = 6;
  localparam logic [CNT6_W-1:0] CNT6_MAX = '1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PLATE_CACHE = 2'd0;
  localparam logic [1:0] CFG_RETRY       = 2'd1;
  localparam logic [1:0] CFG_PLATE_BUDG  = 2'd2;
  localparam logic [1:0] CFG_RECOG_BUDG  = 2'd3;

  // Priority classes, lowest value served first
  localparam logic [1:0] PRIO_NEW      = 2'd0;
  localparam logic [1:0] PRIO_NO_PLATE = 2'd1;
  localparam logic [1:0] PRIO_STALE    = 2'd2;
  localparam logic [1:0] PRIO_CACHED   = 2'd3;

  typedef enum logic [1:0] {
    KIND_PLATE   = 2'd0,
    KIND_RECOG   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL_P,
    ST_EVAL_R,
    ST_SHIFT,
    ST_PLACE,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_SUMMARY
  } state_t;

  // One stored track, 52 bits
  typedef struct packed {
    logic [1:0]  prio;
    logic [15:0] wait_cnt;
    logic [15:0] score;
    logic [15:0] id;
    logic        stale;
    logic        due;
  } entry_t;

  // True if a must be ordered strictly ahead of b
  function automatic logic goes_before(entry_t a, entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = (a.prio < b.prio);
    end else if (a.wait_cnt != b.wait_cnt) begin
      res = (a.wait_cnt > b.wait_cnt);
    end else if (a.score != b.score) begin
      res = (a.score > b.score);
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

endpackage

@@ sv/pjs_store.sv @@
module pjs_store #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  pjs_pkg::entry_t     wr_data,
  input  logic [IDX_W-1:0]    rd_addr,
  output pjs_pkg::entry_t     rd_data
);

  pjs_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/pjs_frame_test.sv @@
module pjs_frame_test (
  input  logic [31:0] frame,
  input  logic [31:0] base,
  input  logic [15:0] offset,
  output logic        reached
);

  logic [32:0] limit;

  // Compare frame against base plus offset in 33 bits, no wrap
  assign limit   = {1'b0, base} + {17'b0, offset};
  assign reached = ({1'b0, frame} >= limit);

endmodule

@@ sv/priority_job_selector.sv @@
// Steps: an unstored record is handled in IDLE alone; a stored one passes EVAL_P, EVAL_R,
// one SHIFT step per stored entry it moves past, one more if it stops short of the head
// (none into an empty store), then PLACE. last_track adds WALK_RD, WALK_EV per stored entry,
// a WALK_RD check and SUMMARY; each result strobes out_valid in the cycle after its walk step.
// Throughput: one record at a time, busy high until done; results cannot be stalled.
// Reset (rst_n low, synchronous) clears counts and loads register defaults.
module priority_job_selector #(
  parameter int MAX_TRACKS = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_frame_number,
  input  logic [15:0] in_track_number,
  input  logic        in_is_eligible,
  input  logic        in_is_finalized,
  input  logic        in_is_new,
  input  logic        in_has_plate,
  input  logic [31:0] in_plate_frame,
  input  logic [31:0] in_recog_frame,
  input  logic [15:0] in_wait_frames,
  input  logic [15:0] in_detect_score,
  input  logic        in_last_track,

  output logic        out_valid,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_job_track,
  output logic [5:0]  out_eligible_count,
  output logic [5:0]  out_suppressed_count,
  output logic [5:0]  out_plate_deferred,
  output logic [5:0]  out_cached_count,
  output logic [5:0]  out_recog_deferred,
  output logic        out_final_result,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRACKS);
  localparam int C6 = pjs_pkg::CNT6_W;

  pjs_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [15:0] plate_cache_r, retry_r;
  logic [C6-1:0] plate_budg_r, recog_budg_r;

  // Captured record
  logic [31:0] frame_r, pf_r, rf_r;
  logic [15:0] id_r, wait_r, score_r;
  logic        new_r, has_plate_r, last_r;
  logic        expired_r, expired_nxt;
  pjs_pkg::entry_t new_entry_r, new_entry_nxt;

  // Frame state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] walk_r, walk_nxt;
  logic [C6-1:0] elig_r, elig_nxt, supp_r, supp_nxt;
  logic [C6-1:0] plates_r, plates_nxt, recogs_r, recogs_nxt;
  logic [C6-1:0] pdef_r, pdef_nxt, cached_r, cached_nxt, rdef_r, rdef_nxt;

  // Result register
  logic        ovalid_r, ovalid_nxt;
  pjs_pkg::kind_t okind_r, okind_nxt;
  logic [15:0] otrack_r, otrack_nxt;
  logic [C6-1:0] oelig_r, oelig_nxt, osupp_r, osupp_nxt, opdef_r, opdef_nxt;
  logic [C6-1:0] ocached_r, ocached_nxt, ordef_r, ordef_nxt;
  logic        ofinal_r, ofinal_nxt;

  // Store port and shared frame test
  logic            wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  pjs_pkg::entry_t wr_data, rd_data;
  logic [31:0]     test_base;
  logic [15:0]     test_off;
  logic            test_hit;
  logic            accept, store_it, ahead;
  logic [CNT_W-1:0] pos_m1, pos_m2, cnt_m1;

  assign accept   = start && (state_r == pjs_pkg::ST_IDLE);
  assign store_it = in_is_eligible && !in_is_finalized && (count_r < MAX_CNT);
  assign ahead    = pjs_pkg::goes_before(new_entry_r, rd_data);
  assign pos_m1   = pos_r - CNT_W'(1);
  assign pos_m2   = pos_r - CNT_W'(2);
  assign cnt_m1   = count_r - CNT_W'(1);

  pjs_store #(
    .DEPTH (MAX_TRACKS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Share one 33-bit add and compare between the plate and retry tests
  assign test_base = (state_r == pjs_pkg::ST_EVAL_P) ? pf_r : rf_r;
  assign test_off  = (state_r == pjs_pkg::ST_EVAL_P) ? plate_cache_r : retry_r;

  pjs_frame_test u_test (
    .frame   (frame_r),
    .base    (test_base),
    .offset  (test_off),
    .reached (test_hit)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pjs_pkg::ST_IDLE: begin
        if (start) begin
          if (store_it) begin
            state_nxt = pjs_pkg::ST_EVAL_P;
          end else if (in_last_track) begin
            state_nxt = pjs_pkg::ST_WALK_RD;
          end
        end
      end
      pjs_pkg::ST_EVAL_P: state_nxt = pjs_pkg::ST_EVAL_R;
      pjs_pkg::ST_EVAL_R: begin
        state_nxt = (count_r != '0) ? pjs_pkg::ST_SHIFT : pjs_pkg::ST_PLACE;
      end
      pjs_pkg::ST_SHIFT: begin
        if (!ahead || pos_r <= CNT_W'(1)) begin
          state_nxt = pjs_pkg::ST_PLACE;
        end
      end
      pjs_pkg::ST_PLACE: begin
        state_nxt = last_r ? pjs_pkg::ST_WALK_RD : pjs_pkg::ST_IDLE;
      end
      pjs_pkg::ST_WALK_RD: begin
        state_nxt = (walk_r == count_r) ? pjs_pkg::ST_SUMMARY : pjs_pkg::ST_WALK_EV;
      end
      pjs_pkg::ST_WALK_EV: state_nxt = pjs_pkg::ST_WALK_RD;
      pjs_pkg::ST_SUMMARY: state_nxt = pjs_pkg::ST_IDLE;
      default: state_nxt = pjs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result control
  always_comb begin
    expired_nxt   = expired_r;
    new_entry_nxt = new_entry_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    walk_nxt      = walk_r;
    elig_nxt      = elig_r;
    supp_nxt      = supp_r;
    plates_nxt    = plates_r;
    recogs_nxt    = recogs_r;
    pdef_nxt      = pdef_r;
    cached_nxt    = cached_r;
    rdef_nxt      = rdef_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r[IDX_W-1:0];
    wr_data       = new_entry_r;
    rd_addr       = '0;
    ovalid_nxt    = 1'b0;
    okind_nxt     = pjs_pkg::KIND_PLATE;
    otrack_nxt    = '0;
    oelig_nxt     = '0;
    osupp_nxt     = '0;
    opdef_nxt     = '0;
    ocached_nxt   = '0;
    ordef_nxt     = '0;
    ofinal_nxt    = 1'b0;
    case (state_r)
      pjs_pkg::ST_IDLE: begin
        // Count eligible and suppressed records, saturating
        if (start && in_is_eligible) begin
          if (elig_r != pjs_pkg::CNT6_MAX) begin
            elig_nxt = elig_r + C6'(1);
          end
          if (in_is_finalized && supp_r != pjs_pkg::CNT6_MAX) begin
            supp_nxt = supp_r + C6'(1);
          end
        end
      end
      pjs_pkg::ST_EVAL_P: begin
        expired_nxt = test_hit;
      end
      pjs_pkg::ST_EVAL_R: begin
        // Build the entry and fetch the current tail
        new_entry_nxt.id       = id_r;
        new_entry_nxt.wait_cnt = wait_r;
        new_entry_nxt.score    = score_r;
        new_entry_nxt.stale    = !has_plate_r || expired_r;
        new_entry_nxt.due      = test_hit;
        if (new_r) begin
          new_entry_nxt.prio = pjs_pkg::PRIO_NEW;
        end else if (!has_plate_r) begin
          new_entry_nxt.prio = pjs_pkg::PRIO_NO_PLATE;
        end else if (expired_r) begin
          new_entry_nxt.prio = pjs_pkg::PRIO_STALE;
        end else begin
          new_entry_nxt.prio = pjs_pkg::PRIO_CACHED;
        end
        pos_nxt = count_r;
        rd_addr = cnt_m1[IDX_W-1:0];
      end
      pjs_pkg::ST_SHIFT: begin
        // Move the fetched entry up one slot while the new one goes ahead of it
        if (ahead) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          pos_nxt = pos_m1;
          rd_addr = pos_m2[IDX_W-1:0];
        end
      end
      pjs_pkg::ST_PLACE: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
      pjs_pkg::ST_WALK_RD: begin
        rd_addr = walk_r[IDX_W-1:0];
      end
      pjs_pkg::ST_WALK_EV: begin
        // Grant, defer or only count one entry in store order
        walk_nxt = walk_r + CNT_W'(1);
        if (rd_data.stale) begin
          if (plates_r < plate_budg_r) begin
            plates_nxt = plates_r + C6'(1);
            ovalid_nxt = 1'b1;
            okind_nxt  = pjs_pkg::KIND_PLATE;
            otrack_nxt = rd_data.id;
          end else begin
            pdef_nxt = pdef_r + C6'(1);
          end
        end else begin
          cached_nxt = cached_r + C6'(1);
          if (rd_data.due) begin
            if (recogs_r < recog_budg_r) begin
              recogs_nxt = recogs_r + C6'(1);
              ovalid_nxt = 1'b1;
              okind_nxt  = pjs_pkg::KIND_RECOG;
              otrack_nxt = rd_data.id;
            end else begin
              rdef_nxt = rdef_r + C6'(1);
            end
          end
        end
      end
      pjs_pkg::ST_SUMMARY: begin
        // Emit the summary and clear the frame
        ovalid_nxt  = 1'b1;
        okind_nxt   = pjs_pkg::KIND_SUMMARY;
        oelig_nxt   = elig_r;
        osupp_nxt   = supp_r;
        opdef_nxt   = pdef_r;
        ocached_nxt = cached_r;
        ordef_nxt   = rdef_r;
        ofinal_nxt  = 1'b1;
        count_nxt   = '0;
        walk_nxt    = '0;
        elig_nxt    = '0;
        supp_nxt    = '0;
        plates_nxt  = '0;
        recogs_nxt  = '0;
        pdef_nxt    = '0;
        cached_nxt  = '0;
        rdef_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pjs_pkg::ST_IDLE;
      count_r  <= '0;
      walk_r   <= '0;
      elig_r   <= '0;
      supp_r   <= '0;
      plates_r <= '0;
      recogs_r <= '0;
      pdef_r   <= '0;
      cached_r <= '0;
      rdef_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      walk_r   <= walk_nxt;
      elig_r   <= elig_nxt;
      supp_r   <= supp_nxt;
      plates_r <= plates_nxt;
      recogs_r <= recogs_nxt;
      pdef_r   <= pdef_nxt;
      cached_r <= cached_nxt;
      rdef_r   <= rdef_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Configuration registers, written only between records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plate_cache_r <= 16'd30;
      retry_r       <= 16'd10;
      plate_budg_r  <= C6'(4);
      recog_budg_r  <= C6'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pjs_pkg::CFG_PLATE_CACHE: plate_cache_r <= cfg_data;
        pjs_pkg::CFG_RETRY:       retry_r       <= cfg_data;
        pjs_pkg::CFG_PLATE_BUDG:  plate_budg_r  <= cfg_data[C6-1:0];
        pjs_pkg::CFG_RECOG_BUDG:  recog_budg_r  <= cfg_data[C6-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_r     <= in_frame_number;
      id_r        <= in_track_number;
      new_r       <= in_is_new;
      has_plate_r <= in_has_plate;
      pf_r        <= in_plate_frame;
      rf_r        <= in_recog_frame;
      wait_r      <= in_wait_frames;
      score_r     <= in_detect_score;
      last_r      <= in_last_track;
    end
    expired_r   <= expired_nxt;
    new_entry_r <= new_entry_nxt;
    pos_r       <= pos_nxt;
    okind_r     <= okind_nxt;
    otrack_r    <= otrack_nxt;
    oelig_r     <= oelig_nxt;
    osupp_r     <= osupp_nxt;
    opdef_r     <= opdef_nxt;
    ocached_r   <= ocached_nxt;
    ordef_r     <= ordef_nxt;
    ofinal_r    <= ofinal_nxt;
  end

  assign busy                 = (state_r != pjs_pkg::ST_IDLE);
  assign cfg_ready            = (state_r == pjs_pkg::ST_IDLE);
  assign out_valid            = ovalid_r;
  assign out_result_kind      = okind_r;
  assign out_job_track        = otrack_r;
  assign out_eligible_count   = oelig_r;
  assign out_suppressed_count = osupp_r;
  assign out_plate_deferred   = opdef_r;
  assign out_cached_count     = ocached_r;
  assign out_recog_deferred   = ordef_r;
  assign out_final_result     = ofinal_r;

endmodule
